// ===== design/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon test.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int unsigned MaxVertices = 6;
  localparam int CoordW   = 32;
  localparam int CntW     = 3;
  localparam int CfgAddrW = 6;
  localparam int CfgDataW = 64;
  localparam int ProdW    = 2 * (CoordW + 1);

  typedef logic [CntW-1:0] cnt_t;

  // register indexes (byte address = 8 * index)
  localparam cnt_t RegVertexCount = 3'd0;
  localparam cnt_t RegVertex0     = 3'd1;
  localparam cnt_t RegVertex1     = 3'd2;
  localparam cnt_t RegVertex2     = 3'd3;
  localparam cnt_t RegVertex3     = 3'd4;
  localparam cnt_t RegVertex4     = 3'd5;
  localparam cnt_t RegVertex5     = 3'd6;

  // y in the upper word, x in the lower word
  typedef struct packed {
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } vertex_t;

  // per-edge verdict from the shared edge unit
  typedef struct packed {
    logic straddle;  // edge y span straddles the point row
    logic left;      // point strictly left of the edge
    logic on_row;    // point on vertex-i row within the edge x span
  } edge_res_t;

endpackage

// ===== design/pip_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pip_cfg_regs
// APB register file: vertex count and six packed vertices.
// ----------------------------------------------------------------------------
module pip_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pip_pkg::CfgAddrW-1:0]  paddr,
  input  logic [pip_pkg::CfgDataW-1:0]  pwdata,
  output logic [pip_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output pip_pkg::cnt_t                 vertex_count_o,
  output pip_pkg::vertex_t              vertex_o [pip_pkg::MaxVertices]
);
  import pip_pkg::*;

  cnt_t    reg_idx;
  logic    wr_en;
  cnt_t    count_q;
  vertex_t vertex_q [MaxVertices];

  assign reg_idx = paddr[CfgAddrW-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < int'(MaxVertices); k++) begin
        vertex_q[k] <= '0;
      end
    end else if (wr_en) begin
      if (reg_idx == RegVertexCount) begin
        count_q <= pwdata[CntW-1:0];
      end else if (reg_idx inside {[RegVertex0:RegVertex5]}) begin
        vertex_q[reg_idx - RegVertex0] <= pwdata;
      end
    end
  end

  always_comb begin
    case (reg_idx)
      RegVertexCount: prdata = {{(CfgDataW-CntW){1'b0}}, count_q};
      RegVertex0:     prdata = vertex_q[0];
      RegVertex1:     prdata = vertex_q[1];
      RegVertex2:     prdata = vertex_q[2];
      RegVertex3:     prdata = vertex_q[3];
      RegVertex4:     prdata = vertex_q[4];
      RegVertex5:     prdata = vertex_q[5];
      default:        prdata = '0;
    endcase
  end

  assign vertex_count_o = count_q;
  assign vertex_o       = vertex_q;

endmodule

// ===== design/pip_edge_unit.sv =====
// ----------------------------------------------------------------------------
// pip_edge_unit
// Shared edge evaluator: multiplier pair registered, exact compare next.
// ----------------------------------------------------------------------------
module pip_edge_unit (
  input  logic                          clk_i,
  input  logic                          mul_en_i,
  input  logic signed [pip_pkg::CoordW-1:0] px_i,
  input  logic signed [pip_pkg::CoordW-1:0] py_i,
  input  pip_pkg::vertex_t              vi_i,
  input  pip_pkg::vertex_t              vj_i,
  output pip_pkg::edge_res_t            res_o
);
  import pip_pkg::*;

  logic signed [CoordW:0]  dx_p, dx_e, dy_p, dy_e;
  logic signed [ProdW-1:0] prod_l_d, prod_r_d;
  logic signed [ProdW-1:0] prod_l_q, prod_r_q;
  logic                    dy_pos_q, straddle_q, on_row_q;
  logic signed [CoordW-1:0] x_lo, x_hi;

  assign dx_p = {px_i[CoordW-1], px_i} - {vi_i.x[CoordW-1], vi_i.x};
  assign dx_e = {vj_i.x[CoordW-1], vj_i.x} - {vi_i.x[CoordW-1], vi_i.x};
  assign dy_p = {py_i[CoordW-1], py_i} - {vi_i.y[CoordW-1], vi_i.y};
  assign dy_e = {vj_i.y[CoordW-1], vj_i.y} - {vi_i.y[CoordW-1], vi_i.y};

  // (px - xi) * dy against (xj - xi) * (py - yi)
  assign prod_l_d = dx_p * dy_e;
  assign prod_r_d = dx_e * dy_p;

  assign x_lo = (vi_i.x < vj_i.x) ? vi_i.x : vj_i.x;
  assign x_hi = (vi_i.x < vj_i.x) ? vj_i.x : vi_i.x;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_l_q   <= prod_l_d;
      prod_r_q   <= prod_r_d;
      dy_pos_q   <= (dy_e > 0);
      straddle_q <= (vi_i.y > py_i) != (vj_i.y > py_i);
      on_row_q   <= (vi_i.y == py_i) && (px_i >= x_lo) && (px_i <= x_hi);
    end
  end

  // compare reverses when dy is not positive
  always_comb begin
    res_o.straddle = straddle_q;
    res_o.on_row   = on_row_q;
    res_o.left     = dy_pos_q ? (prod_l_q < prod_r_q) : (prod_r_q < prod_l_q);
  end

endmodule

// ===== design/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd crossing test of a Q24.8 point against a configured polygon.
// ----------------------------------------------------------------------------
// Sequence: after the point request is taken, each edge in use (one per vertex in use)
//   passes through SMul then SCmp, then SOut; an empty polygon goes straight to SOut.
// A new point is taken only in idle, after the last result is accepted; each edge
//   uses the shared multiplier pair in SMul and the wide compare in SCmp.
// Reset: asynchronous, active low; sequencer idle, vertex count and vertices 0.
// ----------------------------------------------------------------------------
module point_in_polygon_test (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // point request: [31:0] point_x, [63:32] point_y
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,
  // result: [0] inside_res, [7:1] zero
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pip_pkg::CfgAddrW-1:0]  paddr,
  input  logic [pip_pkg::CfgDataW-1:0]  pwdata,
  output logic [pip_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import pip_pkg::*;

  // sequencer codes
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SMul  = 2'd1;
  localparam logic [1:0] SCmp  = 2'd2;
  localparam logic [1:0] SOut  = 2'd3;

  logic [1:0] state_q, state_d;
  cnt_t       idx_i_q, idx_i_d;
  cnt_t       idx_j_q, idx_j_d;
  cnt_t       last_q, last_d;
  logic       inside_q, inside_d;
  logic signed [CoordW-1:0] px_q, py_q;

  cnt_t      vertex_count;
  vertex_t   vertex [MaxVertices];
  cnt_t      n_used;
  edge_res_t edge_res;
  logic      take_point;

  pip_cfg_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .vertex_count_o (vertex_count),
    .vertex_o       (vertex)
  );

  pip_edge_unit u_edge (
    .clk_i,
    .mul_en_i (state_q == SMul),
    .px_i     (px_q),
    .py_i     (py_q),
    .vi_i     (vertex[idx_i_q]),
    .vj_i     (vertex[idx_j_q]),
    .res_o    (edge_res)
  );

  // a count of seven is treated as the maximum
  assign n_used = (vertex_count > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vertex_count;

  assign s_axis_tready = (state_q == SIdle);
  assign take_point    = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = (state_q == SOut);
  assign m_axis_tdata  = {7'b0, inside_q};

  // point is latched on acceptance
  always_ff @(posedge clk_i) begin
    if (take_point) begin
      px_q <= s_axis_tdata[31:0];
      py_q <= s_axis_tdata[63:32];
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_i_d  = idx_i_q;
    idx_j_d  = idx_j_q;
    last_d   = last_q;
    inside_d = inside_q;
    case (state_q)
      SIdle: begin
        if (take_point) begin
          if (n_used == '0) begin
            inside_d = 1'b1;
            state_d  = SOut;
          end else begin
            // first edge runs from the last vertex to vertex 0
            inside_d = 1'b0;
            idx_i_d  = '0;
            idx_j_d  = n_used - 1'b1;
            last_d   = n_used - 1'b1;
            state_d  = SMul;
          end
        end
      end
      SMul: begin
        state_d = SCmp;
      end
      SCmp: begin
        // toggle on a crossing, then the on-row rule forces inside
        if (edge_res.straddle && edge_res.left) begin
          inside_d = ~inside_q;
        end
        if (edge_res.on_row) begin
          inside_d = 1'b1;
        end
        if (idx_i_q == last_q) begin
          state_d = SOut;
        end else begin
          idx_j_d = idx_i_q;
          idx_i_d = idx_i_q + 1'b1;
          state_d = SMul;
        end
      end
      SOut: begin
        if (m_axis_tready) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      idx_i_q  <= '0;
      idx_j_q  <= '0;
      last_q   <= '0;
      inside_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_i_q  <= idx_i_d;
      idx_j_q  <= idx_j_d;
      last_q   <= last_d;
      inside_q <= inside_d;
    end
  end

endmodule
